[hdl/shds_pkg.sv]
// Shared constants, types and opcodes of the semi-planar half downscaler.
`default_nettype none
package shds_pkg;

  // Frame geometry
  localparam int SRC_WIDTH  = 1280;
  localparam int OUT_HEIGHT = 360;
  localparam int PAIR_COUNT = (SRC_WIDTH + 1) / 2;

  // Field and counter widths
  localparam int BYTE_W = 8;
  localparam int SUM_W  = BYTE_W + 1;
  localparam int AVG_W  = BYTE_W + 2;
  localparam int BAND_W = 9;
  localparam int COL_W  = $clog2(SRC_WIDTH);
  localparam int ROW_W  = $clog2(2 * OUT_HEIGHT);
  localparam int PAIR_W = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int CMP_W  = (ROW_W - 1 > BAND_W) ? ROW_W - 1 : BAND_W;

  localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(12);

  // Last kept chroma position of the frame
  localparam int LAST_COL_MOD     = (SRC_WIDTH - 1) % 4;
  localparam int LAST_CHROMA_COL  = (LAST_COL_MOD >= 2) ?
                                    (SRC_WIDTH - 1 - LAST_COL_MOD + 1) : (SRC_WIDTH - 1);
  localparam int LAST_CHROMA_ROW  = ((OUT_HEIGHT - 1) / 2) * 2;

  // Queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Back-end operations
  localparam logic [1:0] OP_WRITE = 2'd0;  // store a horizontal pair sum
  localparam logic [1:0] OP_AVG   = 2'd1;  // finish a 2x2 average and emit
  localparam logic [1:0] OP_PASS  = 2'd2;  // emit a byte unchanged

  typedef struct packed {
    logic [1:0]        op;
    logic [PAIR_W-1:0] addr;
    logic [SUM_W-1:0]  value;
    logic              is_chroma;
    logic              frame_end;
  } queue_entry_t;

endpackage
`default_nettype wire

[hdl/shds_in_if.sv]
// Input channel: one source frame byte per transaction.
`default_nettype none
interface shds_in_if;
  logic                       valid;
  logic                       ready;
  logic [shds_pkg::BYTE_W-1:0] source_byte;
  logic                       frame_start;

  modport source (output valid, output source_byte, output frame_start, input ready);
  modport sink   (input valid, input source_byte, input frame_start, output ready);
endinterface
`default_nettype wire

[hdl/shds_out_if.sv]
// Output channel: one downscaled byte per transaction.
`default_nettype none
interface shds_out_if;
  logic                       valid;
  logic                       ready;
  logic [shds_pkg::BYTE_W-1:0] out_byte;
  logic                       is_chroma;
  logic                       frame_end;

  modport source (output valid, output out_byte, output is_chroma, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input is_chroma, input frame_end,
                  output ready);
endinterface
`default_nettype wire

[hdl/shds_front.sv]
// Front end: tracks frame position, classifies each byte into a back-end operation.
`default_nettype none
module shds_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [shds_pkg::BAND_W-1:0]  cfg_wdata,
  shds_in_if.sink                           in_ch,
  input  wire logic                         q_full,
  output logic                              q_push,
  output shds_pkg::queue_entry_t            q_entry
);
  import shds_pkg::*;

  logic [BAND_W-1:0] band_rows;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic              in_chroma_plane;
  logic [BYTE_W-1:0] held_left_pixel;

  logic [COL_W-1:0]  col_eff, column_count_next;
  logic [ROW_W-1:0]  row_eff, row_count_next;
  logic              chroma_eff, in_chroma_plane_next;
  logic              accept, emit, band, odd_row, odd_col;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept && emit;

  // Classify the byte at its effective position
  always_comb begin
    col_eff    = in_ch.frame_start ? '0 : column_count;
    row_eff    = in_ch.frame_start ? '0 : row_count;
    chroma_eff = in_ch.frame_start ? 1'b0 : in_chroma_plane;
    odd_row    = row_eff[0];
    odd_col    = col_eff[0];
    band       = CMP_W'(row_eff[ROW_W-1:1]) < CMP_W'(band_rows);
    emit       = 1'b0;
    q_entry.op        = OP_PASS;
    q_entry.addr      = PAIR_W'(col_eff[COL_W-1:1]);
    q_entry.value     = SUM_W'(in_ch.source_byte);
    q_entry.is_chroma = chroma_eff;
    q_entry.frame_end = 1'b0;
    if (!chroma_eff) begin
      if (!odd_col) begin
        emit = !odd_row && !band;
      end else if (!odd_row) begin
        emit          = 1'b1;
        q_entry.op    = OP_WRITE;
        q_entry.value = SUM_W'(held_left_pixel) + SUM_W'(in_ch.source_byte);
      end else begin
        emit          = band;
        q_entry.op    = OP_AVG;
        q_entry.value = SUM_W'(held_left_pixel) + SUM_W'(in_ch.source_byte);
      end
    end else begin
      emit = !odd_row && !col_eff[1];
      q_entry.frame_end = (row_eff == ROW_W'(LAST_CHROMA_ROW)) &&
                          (col_eff == COL_W'(LAST_CHROMA_COL));
    end
  end

  // Advance the raster position
  always_comb begin
    column_count_next    = col_eff + COL_W'(1);
    row_count_next       = row_eff;
    in_chroma_plane_next = chroma_eff;
    if (col_eff == COL_W'(SRC_WIDTH - 1)) begin
      column_count_next = '0;
      row_count_next    = row_eff + ROW_W'(1);
      if (!chroma_eff && row_eff == ROW_W'(2 * OUT_HEIGHT - 1)) begin
        row_count_next       = '0;
        in_chroma_plane_next = 1'b1;
      end else if (chroma_eff && row_eff == ROW_W'(OUT_HEIGHT - 1)) begin
        row_count_next       = '0;
        in_chroma_plane_next = 1'b0;
      end
    end
  end

  // Hold position, band register and the left pixel of each pair
  always_ff @(posedge clk) begin
    if (rst) begin
      band_rows       <= BAND_RESET;
      column_count    <= '0;
      row_count       <= '0;
      in_chroma_plane <= 1'b0;
      held_left_pixel <= '0;
    end else begin
      if (cfg_we) begin
        band_rows <= cfg_wdata;
      end
      if (accept) begin
        column_count    <= column_count_next;
        row_count       <= row_count_next;
        in_chroma_plane <= in_chroma_plane_next;
        if (!chroma_eff && !odd_col) begin
          held_left_pixel <= in_ch.source_byte;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hdl/shds_queue.sv]
// Short queue of classified operations between front and back ends.
`default_nettype none
module shds_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire shds_pkg::queue_entry_t push_entry,
  input  wire logic                   pop,
  output shds_pkg::queue_entry_t      head,
  output logic                        not_empty,
  output logic                        full
);
  import shds_pkg::*;

  queue_entry_t      slots [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == QCNT_W'(QUEUE_DEPTH);

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QIDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QIDX_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/shds_back.sv]
// Back end: pair-sum line memory, average stage and output register.
`default_nettype none
module shds_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire shds_pkg::queue_entry_t head,
  input  wire logic                   not_empty,
  output logic                        pop,
  shds_out_if.source                  out_ch
);
  import shds_pkg::*;

  logic [SUM_W-1:0] pair_sum_line [PAIR_COUNT];

  logic             s1_valid, s1_avg, s1_chroma, s1_end;
  logic [SUM_W-1:0] s1_value;
  logic [SUM_W-1:0] rd_data;
  logic             out_load, s1_ready, s1_load, is_write;
  logic [AVG_W-1:0] avg_sum;

  assign out_load = !out_ch.valid || out_ch.ready;
  assign s1_ready = !s1_valid || out_load;
  assign is_write = head.op == OP_WRITE;
  assign pop      = not_empty && (is_write || s1_ready);
  assign s1_load  = pop && !is_write;
  assign avg_sum  = AVG_W'(rd_data) + AVG_W'(s1_value);

  // Write pair sums, read them back for the odd row
  always_ff @(posedge clk) begin
    if (pop && is_write) begin
      pair_sum_line[head.addr] <= head.value;
    end
    if (s1_load) begin
      rd_data <= pair_sum_line[head.addr];
    end
  end

  // Hold the operation while its line entry is read
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_avg    <= head.op == OP_AVG;
      s1_value  <= head.value;
      s1_chroma <= head.is_chroma;
      s1_end    <= head.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s1_load;
    end
  end

  // Drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_ch.out_byte  <= s1_avg ? avg_sum[AVG_W-1:2] : s1_value[BYTE_W-1:0];
      out_ch.is_chroma <= s1_chroma;
      out_ch.frame_end <= s1_end;
    end
  end

endmodule
`default_nettype wire

[hdl/semiplanar_half_downscaler_top.sv]
// Top level of the semi-planar half downscaler.
//
// channel     direction  payload                              transaction when
// in_ch       in         source_byte[7:0], frame_start         valid && ready
// out_ch      out        out_byte[7:0], is_chroma, frame_end   valid && ready
// cfg_we      in         cfg_wdata[8:0] average_band_rows      cfg_we high
//
// One source byte is taken every cycle while the four-entry operation queue
// has room; results pass through the queue, the line read and the output
// register. The pair-sum line memory has one write and one read port
// and serves at most one operation a cycle. Reset clears position and queue
// and loads the band register with its reset value; the line memory is not
// cleared. A stalled output fills the stage and queue and then drops in_ch.ready.
`default_nettype none
module semiplanar_half_downscaler_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [shds_pkg::BAND_W-1:0]  cfg_wdata,
  shds_in_if.sink                           in_ch,
  shds_out_if.source                        out_ch
);
  import shds_pkg::*;

  queue_entry_t push_entry, head;
  logic         q_push, q_pop, q_full, q_not_empty;

  shds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  shds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  shds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .out_ch    (out_ch)
  );

  // Checks on queue flow and output framing
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !(in_ch.valid && in_ch.ready))
    else $error("input accepted while queue full");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

  a_end_is_chroma: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.frame_end) |-> out_ch.is_chroma)
    else $error("frame end flagged on a luma byte");

endmodule
`default_nettype wire

[dv/semiplanar_half_downscaler_top_test.sv]
// Self-checking testbench for the semi-planar half downscaler top level.
`timescale 1ns / 1ps
module semiplanar_half_downscaler_top_test;
  import shds_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int MAX_GAP       = 16;
  // Idle margin after every expected byte has left the block
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int SEGMENTS      = 6;
  localparam int RUN_MIN       = 60;
  localparam int RUN_MAX       = 100;
  localparam int SEG_IDLED     = 40;
  localparam int TAIL_RUN      = 150;
  localparam int TAIL_IDLED    = 60;
  // About 950 bytes, with both sides idling between transactions; the limit
  // leaves a wide margin over the run.
  localparam longint LIMIT_NS  = 64'd400_000 * CLK_PERIOD;

  localparam logic PLANE_LUMA   = 1'b0;
  localparam logic PLANE_CHROMA = 1'b1;
  localparam logic [BYTE_W-1:0] BYTE_MIN = '0;
  localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              plane;
    logic              last;
  } scaled_byte_t;

  // Tracks the frame position, predicts each output byte and checks it
  class downscaled_frame_tracker;
    logic [BAND_W-1:0] band;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              chroma_plane;
    logic [BYTE_W-1:0] left_pixel;
    logic [SUM_W-1:0]  pair_sums [PAIR_COUNT];
    int                last_col;
    int                last_row;
    scaled_byte_t      pending_bytes [$];
    int                mismatch_count;

    function new();
      band = BAND_RESET;
      col = '0;
      row = '0;
      chroma_plane = 1'b0;
      left_pixel = '0;
      foreach (pair_sums[i]) pair_sums[i] = '0;
      // Last column of the frame whose position mod 4 is 0 or 1
      last_col = SRC_WIDTH - 1;
      while (last_col > 0 && (last_col % 4) >= 2) last_col--;
      last_row = ((OUT_HEIGHT - 1) / 2) * 2;
      mismatch_count = 0;
    endfunction

    function void set_band(logic [BAND_W-1:0] value);
      band = value;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void expect_byte(logic [BYTE_W-1:0] data, logic plane, logic last);
      scaled_byte_t item;
      item.data = data;
      item.plane = plane;
      item.last = last;
      pending_bytes.push_back(item);
    endfunction

    // Apply one accepted source byte
    function void take_source_byte(logic [BYTE_W-1:0] b, logic frame_start);
      logic              in_band;
      logic [PAIR_W-1:0] pair;
      logic [AVG_W-1:0]  total;
      if (frame_start) begin
        col = '0;
        row = '0;
        chroma_plane = 1'b0;
      end
      if (!chroma_plane) begin
        in_band = (row >> 1) < band;
        pair = PAIR_W'(col >> 1);
        if (!col[0]) begin
          left_pixel = b;
          if (!row[0] && !in_band) expect_byte(b, PLANE_LUMA, 1'b0);
        end else if (int'(col >> 1) < PAIR_COUNT) begin
          if (!row[0]) begin
            pair_sums[pair] = SUM_W'(left_pixel) + SUM_W'(b);
          end else if (in_band) begin
            total = AVG_W'(pair_sums[pair]) + AVG_W'(left_pixel) + AVG_W'(b);
            expect_byte(total[AVG_W-1:2], PLANE_LUMA, 1'b0);
          end
        end
      end else if (!row[0] && !col[1]) begin
        expect_byte(b, PLANE_CHROMA,
                    (int'(row) == last_row) && (int'(col) == last_col));
      end
      // Advance the raster position, wrapping planes and frames
      if (int'(col) == SRC_WIDTH - 1) begin
        col = '0;
        row = row + 1'b1;
        if (!chroma_plane && int'(row) >= 2 * OUT_HEIGHT) begin
          row = '0;
          chroma_plane = 1'b1;
        end else if (chroma_plane && int'(row) >= OUT_HEIGHT) begin
          row = '0;
          chroma_plane = 1'b0;
        end
      end else begin
        col = col + 1'b1;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_output_byte(logic [BYTE_W-1:0] data, logic plane, logic last);
      scaled_byte_t want;
      if (pending_bytes.size() == 0) begin
        flag_mismatch($sformatf("output byte %0h with nothing expected", data));
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data)
        flag_mismatch($sformatf("out_byte %0h, expected %0h", data, want.data));
      if (plane !== want.plane)
        flag_mismatch($sformatf("is_chroma %0b, expected %0b", plane, want.plane));
      if (last !== want.last)
        flag_mismatch($sformatf("frame_end %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [BAND_W-1:0] cfg_wdata;
  bit                idle_on;

  shds_in_if  in_ch ();
  shds_out_if out_ch ();

  downscaled_frame_tracker tracker = new();

  semiplanar_half_downscaler_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("semiplanar_half_downscaler_top verification failed");
    $finish;
  end

  // Output side: stall a random number of cycles before each transaction
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      tracker.check_output_byte(out_ch.out_byte, out_ch.is_chroma, out_ch.frame_end);
      @(negedge clk);
    end
  end

  // Send one source byte; called and returns at a falling edge
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic frame_start);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.source_byte = b;
    in_ch.frame_start = frame_start;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_source_byte(b, frame_start);
    @(negedge clk);
  endtask

  // Send a run of random bytes, with a frame start on the first if asked
  task automatic push_run(input int count, input logic start_frame);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 15))
        0:       b = BYTE_MIN;
        1:       b = BYTE_MAX;
        default: b = BYTE_W'($urandom_range(0, 255));
      endcase
      push_byte(b, start_frame && (i == 0));
    end
  endtask

  // Hold the input idle until every expected byte has left the block
  task automatic settle();
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_band(input logic [BAND_W-1:0] value);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    tracker.set_band(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int prefix;
    int band_pick;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.source_byte = '0;
    in_ch.frame_start = 1'b0;
    idle_on = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset band: the top row pair only stores sums, nothing leaves
    push_byte(BYTE_MIN, 1'b0);
    push_byte(BYTE_MAX, 1'b0);
    push_byte(BYTE_MAX, 1'b0);
    push_byte(BYTE_MIN, 1'b0);

    // No band: even columns pass; restart frames mid-row and back to back
    settle();
    write_band('0);
    push_byte(BYTE_MAX, 1'b1);
    push_byte(BYTE_MIN, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hfe, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'haa, 1'b0);
    push_byte(8'h0f, 1'b0);
    push_byte(BYTE_MIN, 1'b1);
    push_byte(BYTE_MAX, 1'b0);
    push_byte(8'h33, 1'b1);
    push_byte(8'hcc, 1'b1);
    push_byte(8'hf0, 1'b0);
    push_byte(BYTE_MAX, 1'b0);
    push_byte(BYTE_MAX, 1'b0);

    // Random segments: a full-rate run from a frame start, then idled bytes
    for (int s = 0; s < SEGMENTS; s++) begin
      case (s)
        0:       band_pick = 0;
        1:       band_pick = OUT_HEIGHT;
        2:       band_pick = (1 << BAND_W) - 1;
        3:       band_pick = 1;
        4:       band_pick = $urandom_range(2, OUT_HEIGHT - 2);
        default: band_pick = OUT_HEIGHT - 1;
      endcase
      settle();
      write_band(BAND_W'(band_pick));
      idle_on = 1'b0;
      prefix = $urandom_range(RUN_MIN, RUN_MAX);
      push_run(prefix, 1'b1);
      idle_on = 1'b1;
      for (int i = 0; i < SEG_IDLED; i++)
        push_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
    end

    // Full-rate run with no band, then idled bytes
    settle();
    idle_on = 1'b0;
    write_band('0);
    push_run(TAIL_RUN, 1'b1);
    idle_on = 1'b1;
    push_run(TAIL_IDLED, 1'b0);

    // Drain and report
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatch_count == 0) begin
      $display("semiplanar_half_downscaler_top verification clean");
    end else begin
      $display("semiplanar_half_downscaler_top verification failed");
    end
    $finish;
  end

endmodule

[semiplanar_half_downscaler_top.f]
hdl/shds_pkg.sv
hdl/shds_in_if.sv
hdl/shds_out_if.sv
hdl/shds_front.sv
hdl/shds_queue.sv
hdl/shds_back.sv
hdl/semiplanar_half_downscaler_top.sv
dv/semiplanar_half_downscaler_top_test.sv
